// ===== rtl/core/tspf_pkg.sv =====
// Shared types and constants for the touch sample pair filter.
// Depends on nothing; imported by every module of the filter.
package tspf_pkg;

    localparam int LIMIT_W   = 10;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 2;

    typedef logic [LIMIT_W-1:0]   t_limit;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [COUNT_W-1:0]   t_count;

    localparam t_cfg_idx CFG_X_LIMIT = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_Y_LIMIT = t_cfg_idx'(1);

    localparam t_limit LIMIT_RESET = t_limit'(160);
    localparam t_count GROUP_HELD  = t_count'(3);

endpackage

// ===== rtl/core/tspf_axis.sv =====
// Spread check and closest-pair average for one axis of a sample group.
// Depends on tspf_pkg for the limit type.
module tspf_axis
    import tspf_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0] i_h0,
    input  logic [SAMPLE_BITS-1:0] i_h1,
    input  logic [SAMPLE_BITS-1:0] i_h2,
    input  logic [SAMPLE_BITS-1:0] i_cur,
    input  t_limit                 i_limit,
    output logic                   o_pass,
    output logic [SAMPLE_BITS-1:0] o_avg
);

    localparam int CW = (SAMPLE_BITS > LIMIT_W) ? SAMPLE_BITS : LIMIT_W;

    function automatic logic [SAMPLE_BITS-1:0] absdiff(
        input logic [SAMPLE_BITS-1:0] a,
        input logic [SAMPLE_BITS-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    logic [SAMPLE_BITS-1:0] d0, d1, d2, d3;
    logic [CW-1:0]          lim;
    logic [SAMPLE_BITS:0]   sum;

    assign d0  = absdiff(i_h0, i_h1);
    assign d1  = absdiff(i_h1, i_h2);
    assign d2  = absdiff(i_h2, i_cur);
    assign d3  = absdiff(i_cur, i_h1);
    assign lim = CW'(i_limit);

    assign o_pass = (CW'(d0) <= lim) && (CW'(d1) <= lim) &&
                    (CW'(d2) <= lim) && (CW'(d3) <= lim);

    always_comb begin
        if (d1 < d2) begin
            sum = (d1 < d3) ? ({1'b0, i_h1} + {1'b0, i_h2})
                            : ({1'b0, i_cur} + {1'b0, i_h1});
        end else begin
            sum = (d2 < d3) ? ({1'b0, i_h2} + {1'b0, i_cur})
                            : ({1'b0, i_cur} + {1'b0, i_h1});
        end
    end

    assign o_avg = sum[SAMPLE_BITS:1];

endmodule

// ===== rtl/core/touch_sample_pair_filter.sv =====
// Touch sample pair filter: holds three pressed samples, checks the fourth against them
// and emits the average of the closest pair, or a release word at once.
// A result passes through an input register, then the result register.
// Throughput is one word per cycle while the output is not stalled, set by the single-pass check and average logic.
// Synchronous active-low reset clears the valid flags and the held count and sets both
// spread limits to 160; the held samples are not reset.
module touch_sample_pair_filter
    import tspf_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  t_cfg_idx               i_cfg_index,
    input  t_limit                 i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_pressure,
    input  logic [SAMPLE_BITS-1:0] i_pos_x,
    input  logic [SAMPLE_BITS-1:0] i_pos_y,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_out_pressure,
    output logic [SAMPLE_BITS-1:0] o_out_x,
    output logic [SAMPLE_BITS-1:0] o_out_y
);

    t_limit r_x_limit, r_y_limit;
    t_count r_held_count, n_held_count;
    logic   r_s1_valid, n_s1_valid;
    logic   r_out_valid, n_out_valid;

    logic [SAMPLE_BITS-1:0] r_s1_pressure, r_s1_x, r_s1_y;
    logic [SAMPLE_BITS-1:0] r_held_x [3];
    logic [SAMPLE_BITS-1:0] r_held_y [3];
    logic [SAMPLE_BITS-1:0] r_out_pressure, r_out_x, r_out_y;

    logic                   in_fire, s1_fire, out_free;
    logic                   s1_release, s1_store, res_valid;
    logic                   x_pass, y_pass;
    logic [SAMPLE_BITS-1:0] fx, fy;

    tspf_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
        .i_h0    (r_held_x[0]),
        .i_h1    (r_held_x[1]),
        .i_h2    (r_held_x[2]),
        .i_cur   (r_s1_x),
        .i_limit (r_x_limit),
        .o_pass  (x_pass),
        .o_avg   (fx)
    );

    tspf_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
        .i_h0    (r_held_y[0]),
        .i_h1    (r_held_y[1]),
        .i_h2    (r_held_y[2]),
        .i_cur   (r_s1_y),
        .i_limit (r_y_limit),
        .o_pass  (y_pass),
        .o_avg   (fy)
    );

    assign o_cfg_ready = 1'b1;

    assign s1_release = (r_s1_pressure == '0);
    assign s1_store   = !s1_release && (r_held_count != GROUP_HELD);
    assign res_valid  = s1_release || (!s1_store && x_pass && y_pass);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_s1_valid && (!res_valid || out_free);
    assign o_in_stall = r_s1_valid && !s1_fire;
    assign in_fire    = i_in_valid && !o_in_stall;

    always_comb begin
        n_s1_valid   = in_fire || (r_s1_valid && !s1_fire);
        n_held_count = r_held_count;
        if (s1_fire) begin
            n_held_count = s1_store ? (r_held_count + t_count'(1)) : '0;
        end
        n_out_valid = r_out_valid && i_out_stall;
        if (s1_fire && res_valid) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_limit    <= LIMIT_RESET;
            r_y_limit    <= LIMIT_RESET;
            r_held_count <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_X_LIMIT: r_x_limit <= i_cfg_data;
                    CFG_Y_LIMIT: r_y_limit <= i_cfg_data;
                    default: ;
                endcase
            end
            r_held_count <= n_held_count;
            r_s1_valid   <= n_s1_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_pressure <= i_pressure;
            r_s1_x        <= i_pos_x;
            r_s1_y        <= i_pos_y;
        end
        for (int i = 0; i < 3; i++) begin
            if (s1_fire && s1_store && (r_held_count == t_count'(i))) begin
                r_held_x[i] <= r_s1_x;
                r_held_y[i] <= r_s1_y;
            end
        end
        if (s1_fire && res_valid) begin
            r_out_pressure <= r_s1_pressure;
            r_out_x        <= s1_release ? r_s1_x : fx;
            r_out_y        <= s1_release ? r_s1_y : fy;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_pressure = r_out_pressure;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;

`ifndef SYNTHESIS
    a_release_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_release) |=>
        (o_out_valid && (o_out_pressure == '0) && (r_held_count == '0)))
        else $error("release word did not produce a result or clear the count");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_store) |=>
        (r_held_count == ($past(r_held_count) + t_count'(1))))
        else $error("held count did not advance on a stored sample");

    a_stall_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");
`endif

endmodule

// ===== dv/testbench.sv =====
// Testbench for touch_sample_pair_filter: a directed table of samples, then random sample groups
// under several spread limit settings, each output word checked against an in-bench predictor or a typed row.
// Depends on tspf_pkg and the filter RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tspf_pkg::*;

    localparam int SB           = 10;
    localparam int SMAX         = (1 << SB) - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1150;
    localparam int PHASES       = 8;
    localparam int DIRECTED     = 25;

    // The block has no register at this index and must ignore writes to it.
    localparam t_cfg_idx CFG_SPARE = t_cfg_idx'(3);

    typedef logic [SB-1:0] t_sample;
    typedef struct packed {
        t_sample pressure;
        t_sample x;
        t_sample y;
    } t_touch_word;
    typedef enum logic {CHK_MODEL, CHK_TYPED} t_row_check;
    typedef struct {
        t_touch_word stim;
        t_row_check  chk;
        t_touch_word want;
    } t_stim_row;

    localparam t_touch_word NO_WORD = '0;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    t_limit   i_cfg_data;
    logic     i_in_valid;
    logic     o_in_stall;
    t_sample  i_pressure;
    t_sample  i_pos_x;
    t_sample  i_pos_y;
    logic     o_out_valid;
    logic     i_out_stall;
    t_sample  o_out_pressure;
    t_sample  o_out_x;
    t_sample  o_out_y;

    t_sample     held_x [3];
    t_sample     held_y [3];
    t_count      held_n = '0;
    t_limit      lim_x  = LIMIT_RESET;
    t_limit      lim_y  = LIMIT_RESET;
    t_touch_word pending_events [$];
    t_touch_word head_word;
    int          words_sent   = 0;
    int          error_count  = 0;
    int          cycle_count  = 0;
    int          in_gap_every = 4;
    bit          no_idling    = 1'b0;

    t_stim_row directed_rows [DIRECTED] = '{
        '{'{0, 1023, 0}, CHK_TYPED, '{0, 1023, 0}},
        '{'{0, 0, 1023}, CHK_TYPED, '{0, 0, 1023}},
        '{'{1023, 100, 200}, CHK_MODEL, NO_WORD},
        '{'{1023, 110, 205}, CHK_MODEL, NO_WORD},
        '{'{1023, 120, 210}, CHK_MODEL, NO_WORD},
        '{'{1023, 115, 212}, CHK_MODEL, NO_WORD},
        '{'{1, 1023, 0}, CHK_MODEL, NO_WORD},
        '{'{1, 1023, 0}, CHK_MODEL, NO_WORD},
        '{'{1, 1023, 0}, CHK_MODEL, NO_WORD},
        '{'{1, 1023, 0}, CHK_TYPED, '{1, 1023, 0}},
        '{'{5, 0, 0}, CHK_MODEL, NO_WORD},
        '{'{5, 161, 0}, CHK_MODEL, NO_WORD},
        '{'{5, 161, 0}, CHK_MODEL, NO_WORD},
        '{'{5, 161, 0}, CHK_MODEL, NO_WORD},
        '{'{512, 500, 0}, CHK_MODEL, NO_WORD},
        '{'{512, 500, 0}, CHK_MODEL, NO_WORD},
        '{'{512, 500, 0}, CHK_MODEL, NO_WORD},
        '{'{512, 500, 161}, CHK_MODEL, NO_WORD},
        '{'{700, 0, 0}, CHK_MODEL, NO_WORD},
        '{'{700, 160, 10}, CHK_MODEL, NO_WORD},
        '{'{700, 0, 11}, CHK_MODEL, NO_WORD},
        '{'{700, 160, 30}, CHK_MODEL, NO_WORD},
        '{'{300, 40, 50}, CHK_MODEL, NO_WORD},
        '{'{300, 41, 51}, CHK_MODEL, NO_WORD},
        '{'{0, 600, 700}, CHK_TYPED, '{0, 600, 700}}
    };

    touch_sample_pair_filter #(
        .SAMPLE_BITS(SB)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pressure    (i_pressure),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_pressure(o_out_pressure),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_sample spread_of(input t_sample a, input t_sample b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic bit closest_pair_mean(input t_sample h0, input t_sample h1,
                                             input t_sample h2, input t_sample cur,
                                             input t_limit lim, output t_sample mean);
        t_sample     d0;
        t_sample     d1;
        t_sample     d2;
        t_sample     d3;
        logic [SB:0] sum;
        d0 = spread_of(h0, h1);
        d1 = spread_of(h1, h2);
        d2 = spread_of(h2, cur);
        d3 = spread_of(cur, h1);
        mean = '0;
        if (d0 > lim || d1 > lim || d2 > lim || d3 > lim) return 1'b0;
        if (d1 < d2) begin
            sum = (d1 < d3) ? {1'b0, h1} + h2 : {1'b0, cur} + h1;
        end else begin
            sum = (d2 < d3) ? {1'b0, h2} + cur : {1'b0, cur} + h1;
        end
        mean = sum[SB:1];
        return 1'b1;
    endfunction

    function automatic bit predict_sample(input t_touch_word w, output t_touch_word res);
        t_sample fx;
        t_sample fy;
        res = NO_WORD;
        if (w.pressure == '0) begin
            held_n = '0;
            res = '{'0, w.x, w.y};
            return 1'b1;
        end
        if (held_n < GROUP_HELD) begin
            held_x[held_n] = w.x;
            held_y[held_n] = w.y;
            held_n = held_n + 1'b1;
            return 1'b0;
        end
        held_n = '0;
        if (!closest_pair_mean(held_x[0], held_x[1], held_x[2], w.x, lim_x, fx)) return 1'b0;
        if (!closest_pair_mean(held_y[0], held_y[1], held_y[2], w.y, lim_y, fy)) return 1'b0;
        res = '{w.pressure, fx, fy};
        return 1'b1;
    endfunction

    function automatic int pick_spread(input t_limit lim);
        int s;
        if ($urandom_range(0, 3) == 0) begin
            s = $urandom_range(0, 3);
        end else begin
            s = $urandom_range(0, int'(lim) + int'(lim) / 4 + 1);
        end
        if (s > SMAX) s = SMAX;
        return s;
    endfunction

    task automatic write_spread_limit(input t_cfg_idx idx, input t_limit value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_X_LIMIT: lim_x = value;
            CFG_Y_LIMIT: lim_y = value;
            default: ;
        endcase
    endtask

    task automatic send_word(input t_touch_word w, input t_row_check chk,
                             input t_touch_word want);
        t_touch_word res;
        bit          emits;
        if (!no_idling && in_gap_every != 0 && $urandom_range(1, in_gap_every) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pressure <= w.pressure;
        i_pos_x    <= w.x;
        i_pos_y    <= w.y;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
        emits = predict_sample(w, res);
        if (chk == CHK_TYPED) begin
            pending_events.push_back(want);
        end else if (emits) begin
            pending_events.push_back(res);
        end
    endtask

    task automatic play_random_group();
        int          kind;
        int          n;
        int          sx;
        int          sy;
        t_sample     bx;
        t_sample     by;
        t_touch_word w;
        kind = $urandom_range(0, 9);
        sx = pick_spread(lim_x);
        sy = pick_spread(lim_y);
        bx = t_sample'($urandom_range(0, SMAX - sx));
        by = t_sample'($urandom_range(0, SMAX - sy));
        if (kind <= 5) begin
            n = 4;
        end else if (kind == 6) begin
            n = 0;
        end else if (kind == 7) begin
            n = $urandom_range(1, 3);
        end else begin
            n = -1;
        end
        if (n >= 0) begin
            for (int i = 0; i < n; i++) begin
                w.pressure = t_sample'($urandom_range(1, SMAX));
                w.x = bx + t_sample'($urandom_range(0, sx));
                w.y = by + t_sample'($urandom_range(0, sy));
                send_word(w, CHK_MODEL, NO_WORD);
            end
            if (n < 4) begin
                w = '{'0, t_sample'($urandom_range(0, SMAX)), t_sample'($urandom_range(0, SMAX))};
                send_word(w, CHK_MODEL, NO_WORD);
            end
        end else begin
            repeat ($urandom_range(1, 4)) begin
                w.pressure = ($urandom_range(0, 7) == 0) ? '0 : t_sample'($urandom_range(1, SMAX));
                w.x = t_sample'($urandom_range(0, SMAX));
                w.y = t_sample'($urandom_range(0, SMAX));
                send_word(w, CHK_MODEL, NO_WORD);
            end
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        forever begin
            if (no_idling) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 5))
                    0, 1: begin
                        i_out_stall <= 1'b1;
                        repeat ($urandom_range(1, 19)) @(posedge i_clk);
                    end
                    2: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(100, 300)) @(posedge i_clk);
                    end
                    default: begin
                        i_out_stall <= 1'b0;
                        repeat ($urandom_range(1, 40)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                $error("unexpected output word: pressure %0d x %0d y %0d",
                       o_out_pressure, o_out_x, o_out_y);
                error_count++;
            end else begin
                head_word = pending_events.pop_front();
                if (o_out_pressure !== head_word.pressure) begin
                    $error("out_pressure: expected %0d, got %0d", head_word.pressure,
                           o_out_pressure);
                    error_count++;
                end
                if (o_out_x !== head_word.x) begin
                    $error("out_x: expected %0d, got %0d", head_word.x, o_out_x);
                    error_count++;
                end
                if (o_out_y !== head_word.y) begin
                    $error("out_y: expected %0d, got %0d", head_word.y, o_out_y);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_X_LIMIT;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_pressure  <= '0;
        i_pos_x     <= '0;
        i_pos_y     <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_word(directed_rows[r].stim, directed_rows[r].chk, directed_rows[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                1: begin
                    write_spread_limit(CFG_X_LIMIT, '0);
                    write_spread_limit(CFG_Y_LIMIT, '0);
                end
                2: begin
                    write_spread_limit(CFG_X_LIMIT, '1);
                    write_spread_limit(CFG_Y_LIMIT, '1);
                end
                3: begin
                    write_spread_limit(CFG_X_LIMIT, '0);
                    write_spread_limit(CFG_Y_LIMIT, '1);
                end
                4: begin
                    write_spread_limit(CFG_X_LIMIT, '1);
                    write_spread_limit(CFG_Y_LIMIT, '0);
                end
                5, 6: begin
                    write_spread_limit(CFG_Y_LIMIT, t_limit'($urandom_range(0, SMAX)));
                    write_spread_limit(CFG_X_LIMIT, t_limit'($urandom_range(0, SMAX)));
                end
                7: begin
                    write_spread_limit(CFG_X_LIMIT, LIMIT_RESET);
                    write_spread_limit(CFG_SPARE, t_limit'($urandom_range(0, SMAX)));
                    write_spread_limit(CFG_Y_LIMIT, LIMIT_RESET);
                end
                default: ;
            endcase
            i_cfg_valid <= 1'b0;
            in_gap_every = (phase % 3 == 2) ? 0 : $urandom_range(2, 8);
            no_idling = (phase == PHASES - 1);
            while (words_sent < DIRECTED + (phase + 1) * RANDOM_WORDS / PHASES) begin
                play_random_group();
            end
        end

        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
